// ===== rtl/one_wire_temperature_master_assert.svh =====
// assertion macros for the single-wire temperature master checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ONE_WIRE_TEMPERATURE_MASTER_ASSERT_SVH
`define ONE_WIRE_TEMPERATURE_MASTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define OWT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("one_wire_temperature_master assertion failed");

// next-cycle implication, held off during reset
`define OWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("one_wire_temperature_master assertion failed");

`endif

// ===== rtl/owt_pkg.sv =====
// shared types, codes and helper functions of the single-wire temperature master
// no dependencies
package owt_pkg;

  localparam int unsigned TIMER_BITS_DEF = 9;
  localparam int unsigned CFG_W          = 9;
  localparam int unsigned CFG_ADDR_W     = 3;

  // operation codes, equal to the cmd codes that start them
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_TEMP  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_RESET,
    K_WRITE,
    K_READ
  } kind_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_PRES_TAIL   = 3'd2,
    REG_START_PULSE = 3'd3,
    REG_WRITE_SLOT  = 3'd4,
    REG_READ_SAMPLE = 3'd5,
    REG_READ_TAIL   = 3'd6
  } cfg_reg_e;

  // steps of the temperature sequence
  localparam logic [3:0] STEP_SKIP_A     = 4'd1;
  localparam logic [3:0] STEP_CONVERT    = 4'd2;
  localparam logic [3:0] STEP_POLL       = 4'd3;
  localparam logic [3:0] STEP_SKIP_B     = 4'd5;
  localparam logic [3:0] STEP_READ_SCR   = 4'd6;
  localparam logic [3:0] STEP_READ_LOW   = 4'd7;
  localparam logic [3:0] STEP_READ_HIGH  = 4'd8;
  localparam logic [3:0] STEP_LAST       = 4'd9;

  localparam logic [7:0] ROM_SKIP        = 8'hCC;
  localparam logic [7:0] FN_CONVERT      = 8'h44;
  localparam logic [7:0] FN_READ_SCRATCH = 8'hBE;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_MID  = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       line_in;
  } in_beat_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_missing;
    logic [7:0]        byte_read;
    logic signed [7:0] temperature;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_W-1:0]      wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] pres_wait;
    logic [CFG_W-1:0] pres_tail;
    logic [CFG_W-1:0] start_pulse;
    logic [CFG_W-1:0] write_slot;
    logic [CFG_W-1:0] read_sample;
    logic [CFG_W-1:0] read_tail;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low:   9'd480,
    pres_wait:   9'd60,
    pres_tail:   9'd420,
    start_pulse: 9'd1,
    write_slot:  9'd60,
    read_sample: 9'd14,
    read_tail:   9'd45
  };

  function automatic kind_e slot_kind(op_e op, logic [3:0] step);
    kind_e k;
    k = K_RESET;
    case (op)
      OP_RESET: k = K_RESET;
      OP_WRITE: k = K_WRITE;
      OP_READ:  k = K_READ;
      default: begin
        case (step) inside
          STEP_SKIP_A, STEP_CONVERT, STEP_SKIP_B, STEP_READ_SCR: k = K_WRITE;
          STEP_POLL, STEP_READ_LOW, STEP_READ_HIGH:              k = K_READ;
          default:                                               k = K_RESET;
        endcase
      end
    endcase
    return k;
  endfunction

  // byte loaded into the shifter when a sequence step starts
  function automatic logic [7:0] step_byte(logic [3:0] step);
    logic [7:0] b;
    case (step) inside
      STEP_SKIP_A, STEP_SKIP_B: b = ROM_SKIP;
      STEP_CONVERT:             b = FN_CONVERT;
      STEP_READ_SCR:            b = FN_READ_SCRATCH;
      default:                  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/owt_stream_if.sv =====
// valid/ready channel carrying one payload beat of type T
// no dependencies
interface owt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/one_wire_temperature_master.sv =====
// single-wire bus master with reset, byte write, byte read and temperature sequence
// depends on owt_pkg and owt_stream_if
//
// usage:
//   in_i carries one beat per bus microsecond: a tick or a command (reset, write
//   byte, read byte, read temperature) with the bus level sampled in that
//   microsecond. a command that arrives while an operation runs counts as a tick.
//   out_o returns exactly one beat per input beat: drive_low for that microsecond,
//   busy/done flags and the held presence, byte and temperature results.
//   cfg_i writes the seven timing registers (microseconds); write them only
//   while no operation is running.
// latency and throughput:
//   one input beat per clock; its result is in the output register on the next
//   cycle. the single output register is the only stage, so throughput is one
//   beat per cycle as long as out_o takes beats.
// stalls:
//   while a result waits with out_o.ready low, in_i.ready drops; a beat taken in
//   the same cycle as the waiting result frees the register for the next one.
// reset:
//   rst_ni clears the operation to idle, the held results to zero and the timing
//   registers to 480/60/420/1/60/14/45.
module one_wire_temperature_master #(
  parameter int unsigned TIMER_BITS = owt_pkg::TIMER_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  owt_stream_if.sink   in_i,
  owt_stream_if.source out_o,
  owt_stream_if.sink   cfg_i
);
  import owt_pkg::*;

  typedef logic [TIMER_BITS-1:0] tmr_t;

  // phase length in microseconds, a zero register counts as one
  function automatic tmr_t phase_len(cfg_t c, kind_e k, logic [1:0] ph);
    logic [CFG_W-1:0] v;
    tmr_t             t;
    case (k)
      K_RESET: v = (ph == PH_LOW) ? c.reset_low : (ph == PH_MID) ? c.pres_wait : c.pres_tail;
      K_WRITE: v = (ph == PH_LOW) ? c.start_pulse :
                   (ph == PH_MID) ? c.write_slot : CFG_W'(1);
      default: v = (ph == PH_LOW) ? c.start_pulse :
                   (ph == PH_MID) ? c.read_sample : c.read_tail;
    endcase
    t = tmr_t'(v);
    if (t == '0) begin
      t = tmr_t'(1);
    end
    return t;
  endfunction

  cfg_t        cfg_q;
  op_e         op_q, op_d;
  logic [1:0]  ph_q, ph_d;
  tmr_t        tmr_q, tmr_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [7:0]  sr_q, sr_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  lowb_q, lowb_d;
  logic        pres_q, pres_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic [7:0]  deg_q, deg_d;
  out_beat_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.addr))
        REG_RESET_LOW:   cfg_q.reset_low   <= cfg_i.data.wdata;
        REG_PRES_WAIT:   cfg_q.pres_wait   <= cfg_i.data.wdata;
        REG_PRES_TAIL:   cfg_q.pres_tail   <= cfg_i.data.wdata;
        REG_START_PULSE: cfg_q.start_pulse <= cfg_i.data.wdata;
        REG_WRITE_SLOT:  cfg_q.write_slot  <= cfg_i.data.wdata;
        REG_READ_SAMPLE: cfg_q.read_sample <= cfg_i.data.wdata;
        REG_READ_TAIL:   cfg_q.read_tail   <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    kind_e k;
    logic  adv;
    logic  drive;
    logic  done;

    op_d    = op_q;
    ph_d    = ph_q;
    tmr_d   = tmr_q;
    bidx_d  = bidx_q;
    sr_d    = sr_q;
    step_d  = step_q;
    lowb_d  = lowb_q;
    pres_d  = pres_q;
    rbyte_d = rbyte_q;
    deg_d   = deg_q;
    drive   = 1'b0;
    done    = 1'b0;
    adv     = 1'b0;

    // start a new operation; this beat is its first microsecond
    if (op_q == OP_IDLE && in_i.data.cmd >= OP_RESET && in_i.data.cmd <= OP_TEMP) begin
      op_d   = op_e'(in_i.data.cmd);
      step_d = 4'd0;
      bidx_d = 3'd0;
      sr_d   = (op_d == OP_WRITE) ? in_i.data.data_byte : 8'h00;
      ph_d   = PH_LOW;
      tmr_d  = phase_len(cfg_q, slot_kind(op_d, 4'd0), PH_LOW);
    end

    k = slot_kind(op_d, step_d);

    if (op_d != OP_IDLE) begin
      if (ph_d == PH_LOW) begin
        drive = 1'b1;
      end else if (ph_d == PH_MID && k == K_WRITE) begin
        drive = !sr_d[0];
      end
      // in reset and read slots, sample on the last microsecond of the middle phase
      if (ph_d == PH_MID && tmr_d <= tmr_t'(1) && k != K_WRITE) begin
        if (k == K_RESET) begin
          pres_d = in_i.data.line_in;
        end else begin
          sr_d = {in_i.data.line_in, sr_d[7:1]};
        end
      end
      tmr_d = (tmr_d > tmr_t'(1)) ? tmr_d - tmr_t'(1) : '0;

      if (tmr_d == '0) begin
        if (ph_d == PH_TAIL) begin
          // slot ends
          if (k == K_RESET) begin
            adv = 1'b1;
          end else begin
            if (k == K_WRITE) begin
              sr_d = {1'b0, sr_d[7:1]};
            end
            if (k == K_READ && op_d == OP_TEMP && step_d == STEP_POLL) begin
              // conversion poll: repeat slots until the sensor returns a one
              if (sr_d[7]) begin
                adv = 1'b1;
              end else begin
                ph_d  = PH_LOW;
                tmr_d = phase_len(cfg_q, k, PH_LOW);
              end
            end else if (bidx_d != 3'd7) begin
              bidx_d = bidx_d + 3'd1;
              ph_d   = PH_LOW;
              tmr_d  = phase_len(cfg_q, k, PH_LOW);
            end else begin
              if (k == K_READ) begin
                rbyte_d = sr_d;
                if (op_d == OP_TEMP && step_d == STEP_READ_LOW) begin
                  lowb_d = sr_d;
                end
                if (op_d == OP_TEMP && step_d == STEP_READ_HIGH) begin
                  deg_d = {sr_d[3:0], lowb_d[7:4]};
                end
              end
              adv = 1'b1;
            end
          end
        end else begin
          ph_d  = ph_d + 2'd1;
          tmr_d = phase_len(cfg_q, k, ph_d);
        end
      end

      if (adv) begin
        if (op_d == OP_TEMP && step_d < STEP_LAST) begin
          step_d = step_d + 4'd1;
          bidx_d = 3'd0;
          sr_d   = step_byte(step_d);
          ph_d   = PH_LOW;
          tmr_d  = phase_len(cfg_q, slot_kind(op_d, step_d), PH_LOW);
        end else begin
          op_d  = OP_IDLE;
          ph_d  = PH_LOW;
          tmr_d = '0;
          done  = 1'b1;
        end
      end
    end

    out_d.drive_low        = drive;
    out_d.busy_res         = (op_d != OP_IDLE);
    out_d.done_res         = done;
    out_d.presence_missing = pres_d;
    out_d.byte_read        = rbyte_d;
    out_d.temperature      = deg_d;

    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_IDLE;
      ph_q        <= PH_LOW;
      tmr_q       <= '0;
      bidx_q      <= 3'd0;
      sr_q        <= 8'h00;
      step_q      <= 4'd0;
      lowb_q      <= 8'h00;
      pres_q      <= 1'b0;
      rbyte_q     <= 8'h00;
      deg_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        op_q    <= op_d;
        ph_q    <= ph_d;
        tmr_q   <= tmr_d;
        bidx_q  <= bidx_d;
        sr_q    <= sr_d;
        step_q  <= step_d;
        lowb_q  <= lowb_d;
        pres_q  <= pres_d;
        rbyte_q <= rbyte_d;
        deg_q   <= deg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/owt_checker.sv =====
// port-level checks for the single-wire temperature master, bound to the top level
// depends on owt_pkg and one_wire_temperature_master_assert.svh
`include "one_wire_temperature_master_assert.svh"

module owt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input owt_pkg::out_beat_t out_data_i
);
  import owt_pkg::*;

  // a waiting result keeps its beat
  `OWT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  // a full output register that is not drained blocks the input
  `OWT_ASSERT(a_in_blocked, out_valid_i && !out_ready_i, !in_ready_i)
  // every accepted beat yields a result on the next cycle
  `OWT_ASSERT_NEXT(a_one_result, in_valid_i && in_ready_i, out_valid_i)
  // a finishing beat reports the block idle
  `OWT_ASSERT(a_done_idle, out_valid_i && out_data_i.done_res, !out_data_i.busy_res)
  // the bus is released whenever no operation is running
  `OWT_ASSERT(a_idle_release, out_valid_i && !out_data_i.busy_res, !out_data_i.drive_low)

endmodule

bind one_wire_temperature_master owt_checker u_owt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
